// ===== hw/rtl/ibp_pkg.sv =====
// Shared constants and types of the intra block predictor.
package ibp_pkg;

  // Pixel format and the widest block the packed ports can carry.
  localparam int IBP_PIX_W      = 8;
  localparam int IBP_MAX_SIZE   = 8;
  localparam int IBP_ROW_W      = IBP_PIX_W * IBP_MAX_SIZE;
  localparam int IBP_IDX_W      = 3;
  localparam int IBP_BLOCK_SIZE = 8;

  // Fill value for neighbours that do not exist.
  localparam logic [IBP_PIX_W-1:0] IBP_MID_GRAY = 8'd128;

  // Fraction bits of the reciprocal used for the DC mean.
  localparam int IBP_RECIP_SHIFT = 24;

  // Prediction modes.
  localparam logic [1:0] MODE_VERT = 2'd0;
  localparam logic [1:0] MODE_HORZ = 2'd1;
  localparam logic [1:0] MODE_DC   = 2'd2;
  localparam logic [1:0] MODE_DIAG = 2'd3;

  // Mode and neighbour availability of the request being expanded.
  typedef struct packed {
    logic [1:0] mode;
    logic       no_top;
    logic       no_left;
  } ibp_ctl_t;

endpackage

// ===== hw/rtl/ibp_row.sv =====
// Builds one predicted row of the block from the held request.
module ibp_row
  import ibp_pkg::*;
#(
  parameter int BLOCK_SIZE = IBP_BLOCK_SIZE,
  parameter int RW         = $clog2(BLOCK_SIZE)
) (
  input  ibp_ctl_t                          ctl,
  input  logic [BLOCK_SIZE*IBP_PIX_W-1:0]   top,
  input  logic [BLOCK_SIZE*IBP_PIX_W-1:0]   left,
  input  logic [IBP_PIX_W-1:0]              corner,
  input  logic [IBP_PIX_W-1:0]              dc,
  input  logic [RW-1:0]                     row,
  output logic [IBP_ROW_W-1:0]              pixels
);

  logic [IBP_PIX_W-1:0] top_px  [BLOCK_SIZE];
  logic [IBP_PIX_W-1:0] left_px [BLOCK_SIZE];
  logic [RW:0]          row_ext;

  assign row_ext = {1'b0, row};

  // Unpack the neighbour pixels.
  for (genvar k = 0; k < BLOCK_SIZE; k++) begin : g_unpack
    assign top_px[k]  = top[k*IBP_PIX_W +: IBP_PIX_W];
    assign left_px[k] = left[k*IBP_PIX_W +: IBP_PIX_W];
  end

  // One lane per column; columns beyond the block read as zero.
  for (genvar c = 0; c < IBP_MAX_SIZE; c++) begin : g_lane
    if (c < BLOCK_SIZE) begin : g_used
      localparam logic [RW:0] COL = (RW+1)'(c);
      logic [RW:0]          up_diff;
      logic [RW:0]          lo_diff;
      logic [IBP_PIX_W-1:0] px;

      assign up_diff = COL - row_ext - (RW+1)'(1);
      assign lo_diff = row_ext - COL - (RW+1)'(1);

      // Mode selection for this column.
      always_comb begin
        px = IBP_MID_GRAY;
        if (!(ctl.no_top && ctl.no_left)) begin
          unique case (ctl.mode)
            MODE_VERT: px = ctl.no_top ? IBP_MID_GRAY : top_px[c];
            MODE_HORZ: px = ctl.no_left ? IBP_MID_GRAY : left_px[row];
            MODE_DC:   px = dc;
            MODE_DIAG: begin
              if (row_ext == COL) begin
                px = (ctl.no_top || ctl.no_left) ? IBP_MID_GRAY : corner;
              end else if (row_ext < COL) begin
                px = ctl.no_top ? IBP_MID_GRAY : top_px[up_diff[RW-1:0]];
              end else begin
                px = ctl.no_left ? IBP_MID_GRAY : left_px[lo_diff[RW-1:0]];
              end
            end
            default:   px = IBP_MID_GRAY;
          endcase
        end
      end

      assign pixels[c*IBP_PIX_W +: IBP_PIX_W] = px;
    end else begin : g_unused
      assign pixels[c*IBP_PIX_W +: IBP_PIX_W] = '0;
    end
  end

endmodule

// ===== hw/rtl/intra_block_predictor.sv =====
// Top level of the intra block predictor: request register, row sequencer, result register.
//
// Each accepted request yields BLOCK_SIZE result rows, top row first, one row per cycle
// while the output is not stalled; the row counter walks the held request. A new request
// is taken in the same cycle in which the previous request's last row is loaded into the
// result register, so blocks stream without gaps. Each row passes from the request
// register through the row builder into the result register. The neighbour sums for
// the DC mode are formed on the way into the request register and divided by a
// reciprocal multiply while rows are produced.
module intra_block_predictor
  import ibp_pkg::*;
#(
  parameter int BLOCK_SIZE = IBP_BLOCK_SIZE
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           cmd,
  input  logic                 first_row,
  input  logic                 first_col,
  input  logic [IBP_ROW_W-1:0] top_row,
  input  logic [IBP_ROW_W-1:0] left_col,
  input  logic [IBP_PIX_W-1:0] corner,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IBP_IDX_W-1:0] row_index,
  output logic [IBP_ROW_W-1:0] row_pixels,
  output logic                 last
);

  localparam int RW      = $clog2(BLOCK_SIZE);
  localparam int BW      = BLOCK_SIZE * IBP_PIX_W;
  localparam int SUM_W   = IBP_PIX_W + $clog2(2 * BLOCK_SIZE);
  localparam int RECIP_W = IBP_RECIP_SHIFT + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RW-1:0] LAST_ROW = RW'(BLOCK_SIZE - 1);
  localparam logic [RECIP_W-1:0] RECIP_ONE =
    RECIP_W'((2 ** IBP_RECIP_SHIFT + BLOCK_SIZE - 1) / BLOCK_SIZE);
  localparam logic [RECIP_W-1:0] RECIP_TWO =
    RECIP_W'((2 ** IBP_RECIP_SHIFT + 2 * BLOCK_SIZE - 1) / (2 * BLOCK_SIZE));

  // Held request.
  logic                 req_valid;
  ibp_ctl_t             req_ctl;
  logic [BW-1:0]        req_top;
  logic [BW-1:0]        req_left;
  logic [IBP_PIX_W-1:0] req_corner;
  logic [SUM_W-1:0]     req_sum;
  logic                 req_wide;
  logic [RW-1:0]        row_cnt;

  logic                 in_xfer;
  logic                 advance;
  logic                 done;
  logic [SUM_W-1:0]     sum_top;
  logic [SUM_W-1:0]     sum_left;
  logic [SUM_W-1:0]     sum_sel;
  logic                 wide_sel;
  logic [RECIP_W-1:0]   recip;
  logic [PROD_W-1:0]    product;
  logic [IBP_PIX_W-1:0] dc;
  logic [IBP_ROW_W-1:0] row_next;

  // Handshake: a row moves whenever the result register is free or being drained.
  assign advance  = req_valid && (!out_valid || !out_stall);
  assign done     = advance && (row_cnt == LAST_ROW);
  assign in_stall = req_valid && !done;
  assign in_xfer  = in_valid && !in_stall;

  // Neighbour sums over the used part of the block.
  always_comb begin
    sum_top  = '0;
    sum_left = '0;
    for (int c = 0; c < BLOCK_SIZE; c++) begin
      sum_top  = sum_top + SUM_W'(top_row[c*IBP_PIX_W +: IBP_PIX_W]);
      sum_left = sum_left + SUM_W'(left_col[c*IBP_PIX_W +: IBP_PIX_W]);
    end
  end

  // Choose which neighbours feed the DC mean.
  always_comb begin
    priority if (first_row) begin
      sum_sel  = sum_left;
      wide_sel = 1'b0;
    end else if (first_col) begin
      sum_sel  = sum_top;
      wide_sel = 1'b0;
    end else begin
      sum_sel  = sum_top + sum_left;
      wide_sel = 1'b1;
    end
  end

  // Request register and row counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      row_cnt   <= '0;
    end else begin
      if (in_xfer) begin
        req_valid <= 1'b1;
        row_cnt   <= '0;
      end else if (done) begin
        req_valid <= 1'b0;
        row_cnt   <= '0;
      end else if (advance) begin
        row_cnt <= row_cnt + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_ctl.mode    <= cmd;
      req_ctl.no_top  <= first_row;
      req_ctl.no_left <= first_col;
      req_top         <= top_row[BW-1:0];
      req_left        <= left_col[BW-1:0];
      req_corner      <= corner;
      req_sum         <= sum_sel;
      req_wide        <= wide_sel;
    end
  end

  // DC mean: truncating division by a reciprocal multiply.
  assign recip   = req_wide ? RECIP_TWO : RECIP_ONE;
  assign product = PROD_W'(req_sum) * PROD_W'(recip);
  assign dc      = product[IBP_RECIP_SHIFT +: IBP_PIX_W];

  ibp_row #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .RW         (RW)
  ) u_row (
    .ctl    (req_ctl),
    .top    (req_top),
    .left   (req_left),
    .corner (req_corner),
    .dc     (dc),
    .row    (row_cnt),
    .pixels (row_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      row_index  <= IBP_IDX_W'(row_cnt);
      row_pixels <= row_next;
      last       <= (row_cnt == LAST_ROW);
    end
  end

  // A transfer in starts the block at its top row.
  a_start_row: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (req_valid && row_cnt == '0))
    else $error("accepted request does not start at row zero");

  // A request stays held until its last row has moved out.
  a_hold_req: assert property (@(posedge clk) disable iff (rst)
    (advance && row_cnt != LAST_ROW) |=> req_valid)
    else $error("request dropped before its last row");

  // Every row that moves lands in the result register.
  a_row_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced row missing from result register");

  // The last flag marks exactly the final row index.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (row_index == IBP_IDX_W'(BLOCK_SIZE - 1))))
    else $error("last flag does not match row index");

endmodule

// ===== sim/intra_block_predictor_test.sv =====
// Self-checking testbench of the intra block predictor: directed modes, then random blocks.
module intra_block_predictor_test;
  import ibp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BS         = IBP_BLOCK_SIZE;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYC  = 24;
  localparam int RAND_ITEMS = 280;

  // One predicted row as the block should present it.
  typedef struct packed {
    logic [IBP_IDX_W-1:0] idx;
    logic [IBP_ROW_W-1:0] pixels;
    logic                 last;
  } pred_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           cmd;
  logic                 first_row;
  logic                 first_col;
  logic [IBP_ROW_W-1:0] top_row;
  logic [IBP_ROW_W-1:0] left_col;
  logic [IBP_PIX_W-1:0] corner;
  logic                 out_valid;
  logic                 out_stall;
  logic [IBP_IDX_W-1:0] row_index;
  logic [IBP_ROW_W-1:0] row_pixels;
  logic                 last;

  pred_row_t pending_rows[$];
  int        error_count = 0;
  bit        no_idle = 0;

  intra_block_predictor dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .first_row  (first_row),
    .first_col  (first_col),
    .top_row    (top_row),
    .left_col   (left_col),
    .corner     (corner),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_index  (row_index),
    .row_pixels (row_pixels),
    .last       (last)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Byte k of a packed row of pixels.
  function automatic logic [7:0] pixel_of(input logic [IBP_ROW_W-1:0] packed_row, input int k);
    return packed_row[8*k +: 8];
  endfunction

  // Truncated mean of the neighbours that exist.
  function automatic logic [7:0] block_dc(input logic no_top, input logic no_left,
                                          input logic [IBP_ROW_W-1:0] top,
                                          input logic [IBP_ROW_W-1:0] left);
    int sum_top;
    int sum_left;
    int mean;
    sum_top  = 0;
    sum_left = 0;
    for (int c = 0; c < BS; c++) begin
      sum_top  += int'(pixel_of(top, c));
      sum_left += int'(pixel_of(left, c));
    end
    if (no_top) mean = sum_left / BS;
    else if (no_left) mean = sum_top / BS;
    else mean = (sum_top + sum_left) / (2 * BS);
    return mean[7:0];
  endfunction

  // Predicted pixel at row r, column c.
  function automatic logic [7:0] predict_pixel(input logic [1:0] mode, input logic no_top,
                                               input logic no_left,
                                               input logic [IBP_ROW_W-1:0] top,
                                               input logic [IBP_ROW_W-1:0] left,
                                               input logic [7:0] crn, input logic [7:0] dc,
                                               input int r, input int c);
    if (no_top && no_left) return IBP_MID_GRAY;
    case (mode)
      MODE_VERT: return no_top ? IBP_MID_GRAY : pixel_of(top, c);
      MODE_HORZ: return no_left ? IBP_MID_GRAY : pixel_of(left, r);
      MODE_DC:   return dc;
      default: begin
        if (r == c) return (no_top || no_left) ? IBP_MID_GRAY : crn;
        if (r < c) return no_top ? IBP_MID_GRAY : pixel_of(top, c - r - 1);
        return no_left ? IBP_MID_GRAY : pixel_of(left, r - c - 1);
      end
    endcase
  endfunction

  // Wait time drawn for one transfer; zero inside a no-idle stretch.
  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 18);
  endfunction

  // Present one block request, wait for its transfer and queue the predicted rows.
  task automatic send_block(input logic [1:0] mode, input logic fr, input logic fc,
                            input logic [IBP_ROW_W-1:0] top,
                            input logic [IBP_ROW_W-1:0] left, input logic [7:0] crn);
    int        gap;
    logic [7:0] dc;
    pred_row_t row;
    gap = draw_wait();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    cmd       <= mode;
    first_row <= fr;
    first_col <= fc;
    top_row   <= top;
    left_col  <= left;
    corner    <= crn;
    do @(posedge clk); while (in_stall);
    dc = block_dc(fr, fc, top, left);
    for (int r = 0; r < BS; r++) begin
      row.idx    = r[IBP_IDX_W-1:0];
      row.pixels = '0;
      for (int c = 0; c < BS; c++)
        row.pixels[8*c +: 8] = predict_pixel(mode, fr, fc, top, left, crn, dc, r, c);
      row.last = (r == BS - 1);
      pending_rows.push_back(row);
    end
  endtask

  // Random packed row, now and then all zeros or all ones.
  function automatic logic [IBP_ROW_W-1:0] random_row();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // The very first block is mid gray whatever the mode.
  task automatic test_first_block();
    send_block(MODE_VERT, 1'b1, 1'b1, '1, '1, 8'hFF);
    send_block(MODE_HORZ, 1'b1, 1'b1, '1, '0, 8'h00);
    send_block(MODE_DC,   1'b1, 1'b1, '1, '1, 8'hFF);
    send_block(MODE_DIAG, 1'b1, 1'b1, 64'h0123_4567_89AB_CDEF, '1, 8'h5A);
  endtask

  // Vertical with the top row present and missing.
  task automatic test_vertical();
    send_block(MODE_VERT, 1'b0, 1'b0, 64'hFEDC_BA98_7654_3210, '1, 8'h11);
    send_block(MODE_VERT, 1'b0, 1'b1, '1, '0, 8'h00);
    send_block(MODE_VERT, 1'b1, 1'b0, '0, '1, 8'hFF);
  endtask

  // Horizontal with the left column present and missing.
  task automatic test_horizontal();
    send_block(MODE_HORZ, 1'b0, 1'b0, '0, 64'h0011_2233_4455_6677, 8'h22);
    send_block(MODE_HORZ, 1'b1, 1'b0, '1, '1, 8'hFF);
    send_block(MODE_HORZ, 1'b0, 1'b1, '1, '1, 8'h80);
  endtask

  // DC at the sum extremes, with truncation and each neighbour missing.
  task automatic test_dc();
    send_block(MODE_DC, 1'b0, 1'b0, '1, '1, 8'h00);
    send_block(MODE_DC, 1'b0, 1'b0, '0, '0, 8'hFF);
    send_block(MODE_DC, 1'b0, 1'b0, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_000F, 8'h00);
    send_block(MODE_DC, 1'b1, 1'b0, '1, 64'h0102_0304_0506_0708, 8'h00);
    send_block(MODE_DC, 1'b0, 1'b1, 64'hFF00_FF00_FF00_FF01, '1, 8'h00);
  endtask

  // Diagonal with both neighbours, without the top and without the left.
  task automatic test_diagonal();
    send_block(MODE_DIAG, 1'b0, 1'b0, 64'h8877_6655_4433_2211, 64'hF8F7_F6F5_F4F3_F2F1, 8'hC3);
    send_block(MODE_DIAG, 1'b0, 1'b0, '1, '0, 8'hFF);
    send_block(MODE_DIAG, 1'b1, 1'b0, 64'h8877_6655_4433_2211, 64'hF8F7_F6F5_F4F3_F2F1, 8'h3C);
    send_block(MODE_DIAG, 1'b0, 1'b1, 64'h8877_6655_4433_2211, 64'hF8F7_F6F5_F4F3_F2F1, 8'h3C);
  endtask

  // Random requests, mostly with both neighbours, with no-idle stretches between.
  task automatic test_random();
    int  sel;
    logic fr;
    logic fc;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 35 == 0) no_idle = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 9);
      fr  = (sel == 0) || (sel == 1);
      fc  = (sel == 0) || (sel == 2);
      send_block(2'($urandom_range(0, 3)), fr, fc, random_row(), random_row(),
                 8'($urandom_range(0, 255)));
    end
    no_idle = 0;
  endtask

  // Stimulus sequence and end of run.
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    cmd       = MODE_VERT;
    first_row = 1'b0;
    first_col = 1'b0;
    top_row   = '0;
    left_col  = '0;
    corner    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_first_block();
    test_vertical();
    test_horizontal();
    test_dc();
    test_diagonal();
    test_random();

    @(negedge clk) in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (pending_rows.size() != 0) begin
      $error("%0d predicted rows never arrived", pending_rows.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: stall for a drawn number of cycles before each row transfer.
  initial begin
    int n;
    out_stall = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      n = draw_wait();
      if (n > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare each row transfer with the oldest predicted row.
  always @(posedge clk) begin : check_rows
    pred_row_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        $error("row transfer with nothing predicted: row_index %0d row_pixels %h",
               row_index, row_pixels);
        error_count++;
      end else begin
        want = pending_rows.pop_front();
        if (row_index !== want.idx) begin
          $error("row_index expected %0d got %0d", want.idx, row_index);
          error_count++;
        end
        if (row_pixels !== want.pixels) begin
          $error("row_pixels expected %h got %h", want.pixels, row_pixels);
          error_count++;
        end
        if (last !== want.last) begin
          $error("last expected %0b got %0b", want.last, last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $error("no transfer for %0d cycles", IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ibp_pkg.sv
hw/rtl/ibp_row.sv
hw/rtl/intra_block_predictor.sv
sim/intra_block_predictor_test.sv
